FILE: rtl/depth_to_color_pixel_registration_assert.svh
// Assertion helpers for the pixel registration checker.
`ifndef DEPTH_TO_COLOR_PIXEL_REGISTRATION_ASSERT_SVH
`define DEPTH_TO_COLOR_PIXEL_REGISTRATION_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define DTCR_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("registration check failed");

// Check a consequence a fixed number of cycles after a trigger.
`define DTCR_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("registration check failed");

`endif

FILE: rtl/dtcr_pkg.sv
package dtcr_pkg;

  localparam int QBITS     = 12;  // quotient bits, covers targets up to 4095
  localparam int ADDR_W    = 6;
  localparam int NUM_REGS  = 7;
  localparam int SHADE_MAX = 255;
  localparam int LATENCY   = 20;
  localparam int DEF_IMAGE_WIDTH  = 640;
  localparam int DEF_IMAGE_HEIGHT = 480;

  localparam logic [2:0] REG_ROW0_A = 3'd0;
  localparam logic [2:0] REG_ROW0_B = 3'd1;
  localparam logic [2:0] REG_ROW1_A = 3'd2;
  localparam logic [2:0] REG_ROW1_B = 3'd3;
  localparam logic [2:0] REG_ROW2_A = 3'd4;
  localparam logic [2:0] REG_ROW2_B = 3'd5;
  localparam logic [2:0] REG_LIMIT  = 3'd6;

  typedef struct packed {
    logic               vld;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic        [23:0] sh_num;
  } dtcr_proj_t;

  typedef struct packed {
    logic [63:0]      rem;
    logic [63:0]      dvs;
    logic [QBITS-1:0] quo;
  } dtcr_lane_t;

  typedef struct packed {
    logic vld;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } dtcr_ctl_t;

  typedef struct packed {
    dtcr_ctl_t  ctl;
    dtcr_lane_t x;
    dtcr_lane_t y;
    dtcr_lane_t sh;
  } dtcr_work_t;

  function automatic logic signed [31:0] coef_lo(input logic [63:0] r);
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] coef_hi(input logic [63:0] r);
    return r[63:32];
  endfunction

endpackage

FILE: rtl/dtcr_proj.sv
module dtcr_proj (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [15:0]          depth,
  input  logic [9:0]           col,
  input  logic [8:0]           row,
  input  logic [5:0][63:0]     coef,
  input  logic [15:0]          limit,
  output dtcr_pkg::dtcr_proj_t proj_o
);
  import dtcr_pkg::*;

  logic               v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [15:0]        d0_r, d1_r, d2_r;
  logic [9:0]         c0_r;
  logic [8:0]         r0_r;
  logic [23:0]        n1_r, n2_r, n3_r, n4_r;
  logic signed [42:0] m_r  [3][2];
  logic signed [44:0] s_r  [3];
  logic signed [61:0] dp_r [3];
  logic signed [63:0] p_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= take && (depth != 16'd0) && (depth < limit);
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= depth;
    c0_r <= col;
    r0_r <= row;
    d1_r <= d0_r;
    d2_r <= d1_r;
    n1_r <= 24'((limit - d0_r) * 8'(SHADE_MAX));
    n2_r <= n1_r;
    n3_r <= n2_r;
    n4_r <= n3_r;
    for (int k = 0; k < 3; k++) begin
      m_r[k][0] <= coef_lo(coef[2*k]) * $signed({1'b0, c0_r});
      m_r[k][1] <= coef_hi(coef[2*k]) * $signed({1'b0, r0_r});
      s_r[k]    <= 45'(m_r[k][0]) + 45'(m_r[k][1]) + 45'(coef_lo(coef[2*k+1]));
      dp_r[k]   <= $signed({1'b0, d2_r}) * s_r[k];
      p_r[k]    <= 64'(dp_r[k]) + 64'(coef_hi(coef[2*k+1]));
    end
  end

  assign proj_o.vld    = v4_r;
  assign proj_o.p0     = p_r[0];
  assign proj_o.p1     = p_r[1];
  assign proj_o.p2     = p_r[2];
  assign proj_o.sh_num = n4_r;

endmodule

FILE: rtl/dtcr_prep.sv
module dtcr_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtcr_pkg::dtcr_proj_t proj_i,
  input  logic [15:0]          limit,
  output dtcr_pkg::dtcr_work_t work_o
);
  import dtcr_pkg::*;

  logic        v5_r;
  logic        nx5_r, ny5_r;
  logic [63:0] mag_r [3];
  logic [23:0] n5_r;
  dtcr_work_t  w_r;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= proj_i.vld && (proj_i.p2 != 64'sd0);
    end
    nx5_r    <= proj_i.p0[63] ^ proj_i.p2[63];
    ny5_r    <= proj_i.p1[63] ^ proj_i.p2[63];
    mag_r[0] <= mag(proj_i.p0);
    mag_r[1] <= mag(proj_i.p1);
    mag_r[2] <= mag(proj_i.p2);
    n5_r     <= proj_i.sh_num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.ctl.vld <= 1'b0;
    end else begin
      w_r.ctl.vld   <= v5_r;
      w_r.ctl.neg_x <= nx5_r;
      w_r.ctl.neg_y <= ny5_r;
      // quotient of 2^QBITS or more can never land inside the image
      w_r.ctl.ovf_x <= {QBITS'(0), mag_r[0]} >= {mag_r[2], QBITS'(0)};
      w_r.ctl.ovf_y <= {QBITS'(0), mag_r[1]} >= {mag_r[2], QBITS'(0)};
      w_r.x  <= '{rem: mag_r[0], dvs: mag_r[2], quo: '0};
      w_r.y  <= '{rem: mag_r[1], dvs: mag_r[2], quo: '0};
      w_r.sh <= '{rem: 64'(n5_r), dvs: 64'(limit), quo: '0};
    end
  end

  assign work_o = w_r;

endmodule

FILE: rtl/dtcr_div_step.sv
module dtcr_div_step #(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtcr_pkg::dtcr_work_t work_i,
  output dtcr_pkg::dtcr_work_t work_o
);
  import dtcr_pkg::*;

  dtcr_work_t w_r;

  // one restoring step: try to take dvs << SHIFT out of the remainder
  function automatic dtcr_lane_t step(input dtcr_lane_t l);
    logic [63+QBITS:0] sh;
    dtcr_lane_t        o;
    sh = {QBITS'(0), l.dvs} << SHIFT;
    o  = l;
    if ({QBITS'(0), l.rem} >= sh) begin
      o.rem        = l.rem - sh[63:0];
      o.quo[SHIFT] = 1'b1;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.ctl.vld <= 1'b0;
    end else begin
      w_r.ctl <= work_i.ctl;
      w_r.x   <= step(work_i.x);
      w_r.y   <= step(work_i.y);
      w_r.sh  <= step(work_i.sh);
    end
  end

  assign work_o = w_r;

endmodule

FILE: rtl/depth_to_color_pixel_registration.sv
// Depth-to-color pixel registration. Each request carries one depth sample in
// millimeters with its column and row; the block projects it through a folded
// 3x4 Q16.16 projection and, when the point lands inside the color image,
// strobes out_valid for one cycle with the target column, row and an overlay
// shade of floor(255*(limit-d)/limit). Samples with zero depth, depth at or
// above depth_limit, a zero denominator or a target outside the image produce
// nothing. busy is always low: a request may be issued every clock, and each
// result passes through the fixed pipeline (five stages of projection
// multiply-adds, two of sign and range preparation, twelve restoring divide
// steps, one output register). The receiver cannot stall, so results must be
// taken in the cycle they appear. Registers sit at byte address 8*i on the
// 64-bit APB-style port; write them only while no request is in flight.
module depth_to_color_pixel_registration #(
  parameter int IMAGE_WIDTH  = dtcr_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = dtcr_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [15:0]                 in_depth_mm,
  input  logic [9:0]                  in_src_col,
  input  logic [8:0]                  in_src_row,
  output logic                        out_valid,
  output logic [9:0]                  out_target_x,
  output logic [8:0]                  out_target_y,
  output logic [7:0]                  out_shade,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtcr_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import dtcr_pkg::*;

  logic [63:0]      cfg_r [NUM_REGS];
  logic [2:0]       reg_idx;
  logic [5:0][63:0] coef;
  logic [15:0]      limit;
  dtcr_proj_t       proj;
  dtcr_work_t       work [QBITS+1];
  logic             ok_x, ok_y;
  logic             out_valid_r;
  logic [9:0]       out_x_r;
  logic [8:0]       out_y_r;
  logic [7:0]       out_shade_r;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  // Register file: hold coefficients and the depth limit, write on the APB access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_ROW0_A] <= 64'd65536;
      cfg_r[REG_ROW0_B] <= 64'd0;
      cfg_r[REG_ROW1_A] <= 64'd65536 << 32;
      cfg_r[REG_ROW1_B] <= 64'd0;
      cfg_r[REG_ROW2_A] <= 64'd0;
      cfg_r[REG_ROW2_B] <= 64'd65536;
      cfg_r[REG_LIMIT]  <= 64'd4000;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == REG_LIMIT) begin
        cfg_r[REG_LIMIT] <= {48'd0, pwdata[15:0]};
      end else if (reg_idx < REG_LIMIT) begin
        cfg_r[reg_idx] <= pwdata;
      end
    end
  end

  // Read back; drop unknown addresses to zero.
  always_comb begin
    prdata = 64'd0;
    if (reg_idx < REG_LIMIT || reg_idx == REG_LIMIT) begin
      prdata = cfg_r[reg_idx];
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      coef[k] = cfg_r[k];
    end
  end
  assign limit = cfg_r[REG_LIMIT][15:0];

  // Projection: multiply-accumulate across five stages.
  dtcr_proj u_proj (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (start && !busy),
    .depth  (in_depth_mm),
    .col    (in_src_col),
    .row    (in_src_row),
    .coef   (coef),
    .limit  (limit),
    .proj_o (proj)
  );

  // Take magnitudes, flag signs and oversize quotients.
  dtcr_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .proj_i (proj),
    .limit  (limit),
    .work_o (work[0])
  );

  // Advance one quotient bit per stage, most significant first.
  for (genvar g = 0; g < QBITS; g++) begin : g_div
    dtcr_div_step #(.SHIFT(QBITS-1-g)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .work_i (work[g]),
      .work_o (work[g+1])
    );
  end

  // A negative quotient that truncates to zero still counts as inside.
  assign ok_x = !work[QBITS].ctl.ovf_x
             && (work[QBITS].x.quo == '0 || !work[QBITS].ctl.neg_x)
             && ({1'b0, work[QBITS].x.quo} < (QBITS+1)'(IMAGE_WIDTH));
  assign ok_y = !work[QBITS].ctl.ovf_y
             && (work[QBITS].y.quo == '0 || !work[QBITS].ctl.neg_y)
             && ({1'b0, work[QBITS].y.quo} < (QBITS+1)'(IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= work[QBITS].ctl.vld && ok_x && ok_y;
    end
    out_x_r     <= work[QBITS].x.quo[9:0];
    out_y_r     <= work[QBITS].y.quo[8:0];
    out_shade_r <= work[QBITS].sh.quo[7:0];
  end

  assign out_valid    = out_valid_r;
  assign out_target_x = out_x_r;
  assign out_target_y = out_y_r;
  assign out_shade    = out_shade_r;

endmodule

FILE: rtl/dtcr_checker.sv
module dtcr_checker #(
  parameter int IMAGE_WIDTH  = dtcr_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = dtcr_pkg::DEF_IMAGE_HEIGHT
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [15:0] in_depth_mm,
  input logic        out_valid,
  input logic [9:0]  out_target_x,
  input logic [8:0]  out_target_y,
  input logic        pready
);
  import dtcr_pkg::*;
  `include "depth_to_color_pixel_registration_assert.svh"

  `DTCR_ASSERT_ALWAYS(a_x_in_image, !out_valid || out_target_x < IMAGE_WIDTH)
  `DTCR_ASSERT_ALWAYS(a_y_in_image, !out_valid || out_target_y < IMAGE_HEIGHT)
  `DTCR_ASSERT_ALWAYS(a_never_busy, !busy && pready)
  `DTCR_ASSERT_DELAY(a_zero_depth_drops, start && !busy && in_depth_mm == 16'd0, LATENCY, !out_valid)

endmodule

bind depth_to_color_pixel_registration dtcr_checker #(
  .IMAGE_WIDTH  (IMAGE_WIDTH),
  .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_dtcr_checker (.*);

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtcr_pkg::*;

  localparam int IMG_W = 640;
  localparam int IMG_H = 480;
  localparam int DRAIN_CYCLES = LATENCY + 5;
  localparam int STALL_LIMIT = 1000;
  localparam int REG_UNUSED = 7;  // address decodes to no register

  // Expected output pixel.
  typedef struct {
    logic [9:0] x;
    logic [8:0] y;
    logic [7:0] shade;
  } pixel_t;

  // Projection predictor and queue of pixels still due from the block.
  class pixel_scoreboard;
    logic [63:0] coef[NUM_REGS];
    pixel_t pending[$];

    function void clear();
      coef[REG_ROW0_A] = 64'd65536;
      coef[REG_ROW0_B] = 64'd0;
      coef[REG_ROW1_A] = 64'd65536 << 32;
      coef[REG_ROW1_B] = 64'd0;
      coef[REG_ROW2_A] = 64'd0;
      coef[REG_ROW2_B] = 64'd65536;
      coef[REG_LIMIT]  = 64'd4000;
    endfunction

    function void set_reg(int idx, logic [63:0] val);
      if (idx >= NUM_REGS) return;
      coef[idx] = (idx == REG_LIMIT) ? {48'd0, val[15:0]} : val;
    endfunction

    function longint project(logic [63:0] ra, logic [63:0] rb, longint d, longint c, longint r);
      longint s;
      s = longint'($signed(ra[31:0])) * c + longint'($signed(ra[63:32])) * r
        + longint'($signed(rb[31:0]));
      return d * s + longint'($signed(rb[63:32]));
    endfunction

    // Note an accepted request; returns 1 when it should produce a pixel.
    function bit note_request(logic [15:0] depth, logic [9:0] col, logic [8:0] row);
      longint d, lim, p0, p1, p2, qx, qy;
      pixel_t px;
      d = depth;
      lim = coef[REG_LIMIT][15:0];
      if (d == 0 || d >= lim) return 0;
      p0 = project(coef[REG_ROW0_A], coef[REG_ROW0_B], d, col, row);
      p1 = project(coef[REG_ROW1_A], coef[REG_ROW1_B], d, col, row);
      p2 = project(coef[REG_ROW2_A], coef[REG_ROW2_B], d, col, row);
      if (p2 == 0) return 0;
      qx = p0 / p2;
      qy = p1 / p2;
      if (qx < 0 || qx >= IMG_W || qy < 0 || qy >= IMG_H) return 0;
      px.x = qx[9:0];
      px.y = qy[8:0];
      px.shade = 8'((255 * (lim - d)) / lim);
      pending.push_back(px);
      return 1;
    endfunction

    // Check one strobed pixel; returns an empty string when it matches.
    function string check_pixel(logic [9:0] x, logic [8:0] y, logic [7:0] shade);
      pixel_t px;
      string msg;
      if (pending.size() == 0)
        return $sformatf("unexpected pixel x=%0d y=%0d shade=%0d", x, y, shade);
      px = pending.pop_front();
      msg = "";
      if (x !== px.x) msg = {msg, $sformatf(" x=%0d want %0d", x, px.x)};
      if (y !== px.y) msg = {msg, $sformatf(" y=%0d want %0d", y, px.y)};
      if (shade !== px.shade) msg = {msg, $sformatf(" shade=%0d want %0d", shade, px.shade)};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [15:0] in_depth_mm;
  logic [9:0] in_src_col;
  logic [8:0] in_src_row;
  logic out_valid;
  logic [9:0] out_target_x;
  logic [8:0] out_target_y;
  logic [7:0] out_shade;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  pixel_scoreboard sb;
  int errors;
  int n_requests;
  int n_pixels;
  int n_phases;
  int quiet_cycles;

  depth_to_color_pixel_registration i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_depth_mm(in_depth_mm), .in_src_col(in_src_col), .in_src_row(in_src_row),
    .out_valid(out_valid), .out_target_x(out_target_x), .out_target_y(out_target_y),
    .out_shade(out_shade),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(string what);
    $display("%0t mismatch:%s", $realtime, what);
    errors++;
  endtask

  // Take every strobed pixel at the edge that ends its cycle.
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid) begin
      msg = sb.check_pixel(out_target_x, out_target_y, out_shade);
      if (msg != "") report(msg);
      quiet_cycles = 0;
    end
  end

  // Stop a run that makes no progress for too long.
  always @(posedge clk) begin
    quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("** depth_to_color_pixel_registration: FAILED **");
      $finish;
    end
  end

  // Write one register over the setup and access cycles, then drop the select.
  task automatic write_reg(int idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
    quiet_cycles = 0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pair(int lo, int hi);
    return {hi[31:0], lo[31:0]};
  endfunction

  function automatic int spread(int n);
    return int'($urandom_range(0, 2 * n)) - n;
  endfunction

  // Let the pipeline empty before touching the registers.
  task automatic drain();
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_all(logic [63:0] r0a, logic [63:0] r0b, logic [63:0] r1a,
                          logic [63:0] r1b, logic [63:0] r2a, logic [63:0] r2b,
                          logic [15:0] lim);
    drain();
    write_reg(REG_ROW0_A, r0a);
    write_reg(REG_ROW0_B, r0b);
    write_reg(REG_ROW1_A, r1a);
    write_reg(REG_ROW1_B, r1b);
    write_reg(REG_ROW2_A, r2a);
    write_reg(REG_ROW2_B, r2b);
    write_reg(REG_LIMIT, {48'd0, lim});
    n_phases++;
  endtask

  // Issue one request, hold it until accepted, then idle for the drawn gap.
  task automatic send(logic [15:0] depth, logic [9:0] col, logic [8:0] row, int gap);
    start <= 1'b1;
    in_depth_mm <= depth;
    in_src_col <= col;
    in_src_row <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (sb.note_request(depth, col, row)) n_pixels++;
    n_requests++;
    quiet_cycles = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_idle(logic [15:0] depth, logic [9:0] col, logic [8:0] row);
    send(depth, col, row, 1);
    @(posedge clk);
  endtask

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Random items: mostly depths below the limit on the image grid, some raw noise.
  task automatic random_items(int count);
    int lim;
    bit burst;
    logic [15:0] d;
    logic [9:0] c;
    logic [8:0] r;
    lim = sb.coef[REG_LIMIT][15:0];
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      if (lim > 1 && $urandom_range(0, 9) < 8) d = 16'($urandom_range(1, lim - 1));
      else d = 16'($urandom);
      if ($urandom_range(0, 9) < 8) begin
        c = 10'($urandom_range(0, IMG_W - 1));
        r = 9'($urandom_range(0, IMG_H - 1));
      end else begin
        c = 10'($urandom);
        r = 9'($urandom);
      end
      send(d, c, r, draw_gap(burst));
    end
    start <= 1'b0;
  endtask

  // Near-identity projection with small skew, shift and perspective terms.
  task automatic load_near_identity(bit mirror, logic [15:0] lim);
    int a[12];
    a[0] = 65536 + spread(6554); a[1] = spread(2000); a[2] = spread(30) * 65536;
    a[3] = spread(1 << 20);
    a[4] = spread(2000); a[5] = 65536 + spread(6554); a[6] = spread(30) * 65536;
    a[7] = spread(1 << 20);
    a[8] = spread(20); a[9] = spread(20); a[10] = 65536 + spread(3000);
    a[11] = spread(1 << 16);
    // Negate every row: the quotients stay the same with a negative denominator.
    if (mirror)
      foreach (a[k]) a[k] = -a[k];
    load_all(pair(a[0], a[1]), pair(a[2], a[3]), pair(a[4], a[5]), pair(a[6], a[7]),
             pair(a[8], a[9]), pair(a[10], a[11]), lim);
  endtask

  initial begin
    logic [15:0] lim;
    sb = new();
    sb.clear();
    errors = 0;
    n_requests = 0;
    n_pixels = 0;
    n_phases = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_depth_mm = '0;
    in_src_col = '0;
    in_src_row = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset projection maps each sample onto its own pixel.
    send_idle(16'd0, 10'd5, 9'd5);          // no reading
    send_idle(16'd4000, 10'd5, 9'd5);       // at the limit
    send_idle(16'hFFFF, 10'd5, 9'd5);       // far beyond the limit
    send_idle(16'd3999, 10'd639, 9'd479);   // nearest the limit, far corner
    send_idle(16'd1, 10'd0, 9'd0);          // nearest depth, origin
    send_idle(16'd1000, 10'd640, 9'd10);    // column just outside
    send_idle(16'd1000, 10'd10, 9'd480);    // row just outside
    send_idle(16'd1000, 10'h3FF, 9'h1FF);   // widest input fields
    send_idle(16'd2500, 10'h2AA, 9'h155);

    // Zero denominator: third row all zero.
    load_all(64'd65536, 64'd0, 64'd65536 << 32, 64'd0, 64'd0, 64'd0, 16'd4000);
    send_idle(16'd100, 10'd10, 9'd10);
    send_idle(16'd3000, 10'd600, 9'd400);

    // Small negative quotient truncates to zero and counts as inside.
    load_all(pair(0, 0), pair(0, -32768), pair(0, 0), pair(0, -32768),
             64'd0, pair(65536, 0), 16'd65535);
    send_idle(16'd1, 10'd3, 9'd3);
    send_idle(16'd65534, 10'd3, 9'd3);      // deepest sample, widest limit

    // Unmapped address must leave the projection alone.
    drain();
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_idle(16'd7, 10'd1, 9'd1);

    // Limit of one and of zero drop every sample.
    load_all(64'd65536, 64'd0, 64'd65536 << 32, 64'd0, 64'd0, 64'd65536, 16'd1);
    send_idle(16'd1, 10'd1, 9'd1);
    drain();
    write_reg(REG_LIMIT, 64'd0);
    send_idle(16'd1, 10'd1, 9'd1);
    send_idle(16'd0, 10'd1, 9'd1);

    // Random phases over a spread of projections and limits.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: lim = 16'hFFFF;
        1: lim = 16'd2;
        default: lim = 16'($urandom_range(1, 65535));
      endcase
      if (ph == 4 || ph == 8)
        load_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, lim);
      else
        load_near_identity(ph % 3 == 2, lim);
      random_items(ph == 1 ? 40 : 130);
    end

    drain();
    $display("covered %0d requests over %0d register settings, %0d pixels predicted",
             n_requests, n_phases, n_pixels);
    if (errors == 0)
      $display("** depth_to_color_pixel_registration: PASSED **");
    else
      $display("** depth_to_color_pixel_registration: FAILED **");
    $finish;
  end

endmodule

FILE: depth_to_color_pixel_registration.f
+incdir+rtl
rtl/dtcr_pkg.sv
rtl/dtcr_proj.sv
rtl/dtcr_prep.sv
rtl/dtcr_div_step.sv
rtl/depth_to_color_pixel_registration.sv
rtl/dtcr_checker.sv
bench/tb.sv
